@@ sv/fgr_pkg.sv @@
`default_nettype none
package fgr_pkg;

    localparam int MAX_INPUTS   = 64;
    localparam int BELIEF_W     = 16;
    localparam int ONE_Q15      = 32768;
    localparam int KIND_W       = 3;
    localparam int THRESH_RESET = 16384;
    localparam int OUT_CNT_W    = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // run counter holds 0..MAX_INPUTS, run sum holds MAX_INPUTS * 1.0
    localparam int CNT_W = $clog2(MAX_INPUTS + 1);
    localparam int SUM_W = $clog2(ONE_Q15 * MAX_INPUTS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_KIND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(1);

    typedef enum logic [KIND_W-1:0] {
        GK_AND     = 3'd0,
        GK_OR      = 3'd1,
        GK_NOT     = 3'd2,
        GK_XOR     = 3'd3,
        GK_IMPLIES = 3'd4
    } t_gate_kind;

    typedef struct packed {
        logic [BELIEF_W-1:0] run_min;
        logic [BELIEF_W-1:0] run_max;
        logic [SUM_W-1:0]    run_sum;
        logic                high_parity;
        logic [CNT_W-1:0]    value_count;
        logic [BELIEF_W-1:0] first_value;
        logic [BELIEF_W-1:0] second_value;
        logic                dropped_flag;
    } t_run;

endpackage
`default_nettype wire

@@ sv/fuzzy_gate_reducer.sv @@
`default_nettype none
// Fuzzy gate reducer. Takes a run of Q1.15 truth values (32768 = 1.0) on the
// input channel, one per transfer, and on the value marked is_last gives one
// result: min (AND), max (OR), 1 - first (NOT), truncated mean when an odd
// number of values reach threshold (XOR), max(1 - first, second) (IMPLIES,
// zero for a run of one value), or zero for other gate kinds. Values above
// 1.0 saturate; values past MAX_INPUTS are dropped and flagged in overflow. A
// value that is not last is taken even while a result waits in the output
// register. For XOR the mean comes from a restoring divider, one quotient bit
// per cycle. Input ready is low from the last transfer until the result is
// loaded into the output register, which waits for the previous result to
// leave. Gate kind and threshold are to be written through the config port
// only while the block is idle; the block itself does not enforce this.
module fuzzy_gate_reducer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wen,
    input  wire logic [fgr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fgr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output      logic                            o_in_ready,
    input  wire logic [fgr_pkg::BELIEF_W-1:0]    i_belief,
    input  wire logic                            i_is_last,
    output      logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    output      logic [fgr_pkg::BELIEF_W-1:0]    o_gate_level,
    output      logic                            o_above_threshold,
    output      logic [fgr_pkg::OUT_CNT_W-1:0]   o_inputs_used,
    output      logic                            o_overflow
);

    localparam int BW    = fgr_pkg::BELIEF_W;
    localparam int CNT_W = fgr_pkg::CNT_W;
    localparam int OUT_W = fgr_pkg::OUT_CNT_W;
    localparam logic [BW:0] ONE_X = (BW + 1)'(fgr_pkg::ONE_Q15);

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,   // taking values
        ST_DIV  = 3'b010,   // XOR mean in the divider
        ST_DONE = 3'b100    // result ready to load
    } t_state;

    t_state r_state;
    t_state n_state;

    fgr_pkg::t_gate_kind     r_kind;
    logic [BW-1:0]           r_threshold;

    fgr_pkg::t_run           w_run;
    logic                    w_in_xfer;
    logic                    w_last_xfer;
    logic                    w_load;
    logic                    r_div_start;
    logic [fgr_pkg::SUM_W-1:0] w_quo;
    logic                    w_div_done;

    logic [BW:0]             w_inv;
    logic [BW-1:0]           w_imp;
    logic [BW-1:0]           w_gate;
    logic [CNT_W+OUT_W-1:0]  w_used_x;

    logic [BW-1:0]           r_gate;
    logic                    r_above;
    logic [OUT_W-1:0]        r_used;
    logic                    r_ovf;
    logic                    r_out_valid;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= fgr_pkg::GK_AND;
            r_threshold <= BW'(fgr_pkg::THRESH_RESET);
        end else if (i_cfg_wen) begin
            if (i_cfg_idx == fgr_pkg::CFG_GATE_KIND) begin
                r_kind <= fgr_pkg::t_gate_kind'(i_cfg_data[fgr_pkg::KIND_W-1:0]);
            end else if (i_cfg_idx == fgr_pkg::CFG_THRESHOLD) begin
                r_threshold <= i_cfg_data[BW-1:0];
            end
        end
    end

    // ---- handshake ----
    assign o_in_ready  = (r_state == ST_RUN);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_last_xfer = w_in_xfer && i_is_last;
    // result moves into the output register once it is free
    assign w_load      = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    fgr_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_in_xfer),
        .i_clear     (w_load),
        .i_belief    (i_belief),
        .i_threshold (r_threshold),
        .o_run       (w_run)
    );

    // divider starts the cycle after the last transfer, on updated run state
    fgr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_run.run_sum),
        .i_divisor  (w_run.value_count),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (w_last_xfer) begin
                    n_state = (r_kind == fgr_pkg::GK_XOR) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= w_last_xfer && (r_kind == fgr_pkg::GK_XOR);
        end
    end

    // ---- gate result ----
    assign w_inv = ONE_X - {1'b0, w_run.first_value};
    assign w_imp = (w_inv[BW-1:0] > w_run.second_value) ? w_inv[BW-1:0]
                                                        : w_run.second_value;

    always_comb begin
        case (r_kind)
            fgr_pkg::GK_AND: w_gate = w_run.run_min;
            fgr_pkg::GK_OR:  w_gate = w_run.run_max;
            fgr_pkg::GK_NOT: w_gate = w_inv[BW-1:0];
            fgr_pkg::GK_XOR: begin
                if (w_run.high_parity && (w_run.value_count != CNT_W'(0))) begin
                    w_gate = w_quo[BW-1:0];
                end else begin
                    w_gate = '0;
                end
            end
            fgr_pkg::GK_IMPLIES: begin
                w_gate = (w_run.value_count < CNT_W'(2)) ? '0 : w_imp;
            end
            default: w_gate = '0;
        endcase
    end

    // count reported modulo 2^OUT_W
    assign w_used_x = (CNT_W + OUT_W)'(w_run.value_count);

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_gate  <= w_gate;
            r_above <= (w_gate >= r_threshold);
            r_used  <= w_used_x[OUT_W-1:0];
            r_ovf   <= w_run.dropped_flag;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_gate_level      = r_gate;
    assign o_above_threshold = r_above;
    assign o_inputs_used     = r_used;
    assign o_overflow        = r_ovf;

`ifndef SYNTHESIS
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result valid without a finished run");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_gate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_gate_level} <= ONE_X))
        else $error("gate output above 1.0");

    a_overflow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow)
            |-> (o_inputs_used == OUT_W'(fgr_pkg::MAX_INPUTS)))
        else $error("overflow flagged before the run was full");
`endif

endmodule
`default_nettype wire

@@ sv/fgr_accum.sv @@
`default_nettype none
module fgr_accum (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic                         i_clear,
    input  wire logic [fgr_pkg::BELIEF_W-1:0] i_belief,
    input  wire logic [fgr_pkg::BELIEF_W-1:0] i_threshold,
    output      fgr_pkg::t_run                o_run
);

    localparam logic [fgr_pkg::BELIEF_W-1:0] ONE =
        fgr_pkg::BELIEF_W'(fgr_pkg::ONE_Q15);
    localparam logic [fgr_pkg::CNT_W-1:0] CNT_MAX =
        fgr_pkg::CNT_W'(fgr_pkg::MAX_INPUTS);

    fgr_pkg::t_run r_run;
    fgr_pkg::t_run n_run;
    logic [fgr_pkg::BELIEF_W-1:0] w_b;

    // belief above 1.0 saturates on entry
    assign w_b = (i_belief > ONE) ? ONE : i_belief;

    always_comb begin
        n_run = r_run;
        if (i_clear) begin
            n_run.run_min      = ONE;
            n_run.run_max      = '0;
            n_run.run_sum      = '0;
            n_run.high_parity  = 1'b0;
            n_run.value_count  = '0;
            n_run.first_value  = '0;
            n_run.second_value = '0;
            n_run.dropped_flag = 1'b0;
        end else if (i_step) begin
            if (r_run.value_count < CNT_MAX) begin
                if (r_run.value_count == fgr_pkg::CNT_W'(0)) begin
                    n_run.first_value = w_b;
                end else if (r_run.value_count == fgr_pkg::CNT_W'(1)) begin
                    n_run.second_value = w_b;
                end
                if (w_b < r_run.run_min) begin
                    n_run.run_min = w_b;
                end
                if (w_b > r_run.run_max) begin
                    n_run.run_max = w_b;
                end
                n_run.run_sum     = r_run.run_sum + fgr_pkg::SUM_W'(w_b);
                n_run.high_parity = r_run.high_parity ^ (w_b >= i_threshold);
                n_run.value_count = r_run.value_count + fgr_pkg::CNT_W'(1);
            end else begin
                n_run.dropped_flag = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run.run_min      <= ONE;
            r_run.run_max      <= '0;
            r_run.run_sum      <= '0;
            r_run.high_parity  <= 1'b0;
            r_run.value_count  <= '0;
            r_run.first_value  <= '0;
            r_run.second_value <= '0;
            r_run.dropped_flag <= 1'b0;
        end else begin
            r_run <= n_run;
        end
    end

    assign o_run = r_run;

endmodule
`default_nettype wire

@@ sv/fgr_div.sv @@
`default_nettype none
module fgr_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [fgr_pkg::SUM_W-1:0] i_dividend,
    input  wire logic [fgr_pkg::CNT_W-1:0] i_divisor,
    output      logic [fgr_pkg::SUM_W-1:0] o_quotient,
    output      logic                      o_done
);

    localparam int DVS_W = fgr_pkg::CNT_W;
    localparam int SUM_W = fgr_pkg::SUM_W;
    localparam int STEP_W = $clog2(SUM_W);

    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [SUM_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DVS_W:0]   w_trial;
    logic             w_fit;
    logic [DVS_W:0]   w_diff;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W - 1);
            end else if (r_busy) begin
                if (r_step == STEP_W'(0)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_fit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule
`default_nettype wire

@@ tb/sv/tb_fuzzy_gate_reducer.sv @@
`timescale 1ns / 100ps
module tb_fuzzy_gate_reducer;

    // Quiet cycles before a register write and at the end: covers the XOR
    // divider plus margin.
    localparam int SETTLE_CYCLES  = 40;
    // Cycles with no transfer of any kind before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_MODE = 575;

    // Register indexes past the end of the map; writes there must be dropped.
    localparam logic [fgr_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = fgr_pkg::CFG_IDX_W'(2);
    localparam logic [fgr_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = fgr_pkg::CFG_IDX_W'(3);
    // Gate kinds without a gate behind them; they yield zero.
    localparam logic [fgr_pkg::KIND_W-1:0]    GK_SPARE_LO = 3'd5;
    localparam logic [fgr_pkg::KIND_W-1:0]    GK_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [fgr_pkg::BELIEF_W-1:0]  gate_out;
        logic                          above;
        logic [fgr_pkg::OUT_CNT_W-1:0] used;
        logic                          ovf;
    } t_result;

    // One line of the directed table: either a register write or a value.
    typedef struct {
        bit                            is_cfg;
        logic [fgr_pkg::CFG_IDX_W-1:0] idx;
        logic [15:0]                   data;    // belief for value rows
        logic                          last;
        bit                            typed;   // expected result written in below
        t_result                       want;
    } t_plan_row;

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_wen   = 1'b0;
    logic [fgr_pkg::CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [fgr_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    logic [fgr_pkg::BELIEF_W-1:0]    i_belief    = '0;
    logic                            i_is_last   = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [fgr_pkg::BELIEF_W-1:0]    o_gate_level;
    logic                            o_above_threshold;
    logic [fgr_pkg::OUT_CNT_W-1:0]   o_inputs_used;
    logic                            o_overflow;

    fuzzy_gate_reducer uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wen         (i_cfg_wen),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_belief          (i_belief),
        .i_is_last         (i_is_last),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_gate_level      (o_gate_level),
        .o_above_threshold (o_above_threshold),
        .o_inputs_used     (o_inputs_used),
        .o_overflow        (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Percent of cycles each side holds off.
    int src_idle = 28;
    int snk_idle = 56;

    int n_items;
    int n_results;
    int n_cfg;
    int n_errors;
    int stall_cycles;

    t_result   gate_q[$];   // gate results still owed by the block
    t_plan_row plan[$];

    // Mirror of the block: registers and the run being reduced.
    fgr_pkg::t_gate_kind cur_kind;
    logic [15:0]         cur_thresh;
    int                  acc_min;
    int                  acc_max;
    int                  acc_sum;
    bit                  acc_parity;
    int                  acc_count;
    int                  acc_first;
    int                  acc_second;
    bit                  acc_dropped;

    function automatic void clear_run();
        acc_min     = fgr_pkg::ONE_Q15;
        acc_max     = 0;
        acc_sum     = 0;
        acc_parity  = 1'b0;
        acc_count   = 0;
        acc_first   = 0;
        acc_second  = 0;
        acc_dropped = 1'b0;
    endfunction

    // Fold one value into the run; on the last value produce the gate result.
    function automatic void absorb_belief(input logic [15:0] belief, input logic last,
                                          output bit has_res, output t_result res);
        int b;
        int g;
        int inv;
        b       = (belief > fgr_pkg::ONE_Q15) ? fgr_pkg::ONE_Q15 : int'(belief);
        has_res = 1'b0;
        res     = '0;
        if (acc_count < fgr_pkg::MAX_INPUTS) begin
            if (acc_count == 0)
                acc_first = b;
            else if (acc_count == 1)
                acc_second = b;
            if (b < acc_min) acc_min = b;
            if (b > acc_max) acc_max = b;
            acc_sum += b;
            // threshold in force when the value arrives
            if (b >= int'(cur_thresh)) acc_parity = ~acc_parity;
            acc_count++;
        end else begin
            acc_dropped = 1'b1;
        end
        if (!last) return;
        case (cur_kind)
            fgr_pkg::GK_AND: g = acc_min;
            fgr_pkg::GK_OR:  g = acc_max;
            fgr_pkg::GK_NOT: g = fgr_pkg::ONE_Q15 - acc_first;
            fgr_pkg::GK_XOR: g = (acc_parity && acc_count != 0) ? acc_sum / acc_count : 0;
            fgr_pkg::GK_IMPLIES: begin
                inv = fgr_pkg::ONE_Q15 - acc_first;
                g   = (acc_count < 2) ? 0 : ((inv > acc_second) ? inv : acc_second);
            end
            default: g = 0;
        endcase
        has_res      = 1'b1;
        res.gate_out = g[fgr_pkg::BELIEF_W-1:0];
        res.above    = (g >= int'(cur_thresh));
        res.used     = acc_count[fgr_pkg::OUT_CNT_W-1:0];
        res.ovf      = acc_dropped;
        clear_run();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t, result %0d, %s: got %0d, expected %0d",
                 $time, n_results, what, got, want);
        n_errors++;
    endtask

    // Offer one value; returns at the edge where it transferred.
    task automatic send_belief(input logic [15:0] b, input logic last,
                               input bit typed, input t_result want);
        bit      has_res;
        t_result pred;
        if ($urandom_range(0, 99) < src_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle);
        end
        i_in_valid <= 1'b1;
        i_belief   <= b;
        i_is_last  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_items++;
        absorb_belief(b, last, has_res, pred);
        if (has_res) gate_q.push_back(typed ? want : pred);
    endtask

    // Register writes only once the block has delivered everything and gone quiet.
    task automatic cfg_write(input logic [fgr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        i_in_valid <= 1'b0;
        while (gate_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_wen  <= 1'b0;
        n_cfg++;
        if (idx == fgr_pkg::CFG_GATE_KIND)
            cur_kind = fgr_pkg::t_gate_kind'(data[fgr_pkg::KIND_W-1:0]);
        else if (idx == fgr_pkg::CFG_THRESHOLD)
            cur_thresh = data;
    endtask

    function automatic void add_cfg(input logic [fgr_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [15:0] data);
        t_plan_row r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        plan.push_back(r);
    endfunction

    // A value row; with typed set, the expected result given here is used.
    function automatic void add_value(input logic [15:0] b, input logic last,
                                      input bit typed = 1'b0, input int g = 0,
                                      input bit above = 1'b0, input int used = 0,
                                      input bit ovf = 1'b0);
        t_plan_row r;
        r               = '{default: '0};
        r.data          = b;
        r.last          = last;
        r.typed         = typed;
        r.want.gate_out = g[fgr_pkg::BELIEF_W-1:0];
        r.want.above    = above;
        r.want.used     = used[fgr_pkg::OUT_CNT_W-1:0];
        r.want.ovf      = ovf;
        plan.push_back(r);
    endfunction

    function automatic logic [15:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(0, fgr_pkg::ONE_Q15));
        endcase
    endfunction

    // Mostly legal beliefs, with saturation, the rails and exact threshold hits.
    function automatic logic [15:0] pick_belief();
        case ($urandom_range(0, 15))
            0, 1:    return 16'($urandom_range(fgr_pkg::ONE_Q15 + 1, 65535));
            2:       return 16'd0;
            3:       return 16'd32768;
            4, 5:    return cur_thresh;
            default: return 16'($urandom_range(0, fgr_pkg::ONE_Q15));
        endcase
    endfunction

    // Mostly short runs; now and then one that runs past MAX_INPUTS.
    function automatic int pick_run_len();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0)
            return $urandom_range(fgr_pkg::MAX_INPUTS - 2, fgr_pkg::MAX_INPUTS + 8);
        if (r < 10)  return 1;
        if (r < 20)  return 2;
        return $urandom_range(3, 12);
    endfunction

    // Receive side: check every transfer against the oldest expectation,
    // then decide whether to stall the next cycle.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (gate_q.size() == 0) begin
                report_mismatch("result with nothing pending", o_gate_level, 0);
            end else begin
                want = gate_q.pop_front();
                if (o_gate_level !== want.gate_out)
                    report_mismatch("gate_level", o_gate_level, want.gate_out);
                if (o_above_threshold !== want.above)
                    report_mismatch("above_threshold", o_above_threshold, want.above);
                if (o_inputs_used !== want.used)
                    report_mismatch("inputs_used", o_inputs_used, want.used);
                if (o_overflow !== want.ovf)
                    report_mismatch("overflow", o_overflow, want.ovf);
                n_results++;
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    // Hang detector: any transfer or register write restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || i_cfg_wen) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results pending",
                     stall_cycles, gate_q.size());
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int       seg;
        int       mode_items;
        int       seg_end;
        int       len;
        t_result  none;
        none       = '0;
        cur_kind   = fgr_pkg::GK_AND;
        cur_thresh = 16'(fgr_pkg::THRESH_RESET);
        clear_run();

        // Directed table. Reset values first: AND, threshold 0.5.
        add_value(16'h8000, 1'b1, 1'b1, 32768, 1'b1, 1, 1'b0);
        add_value(16'hFFFF, 1'b1, 1'b1, 32768, 1'b1, 1, 1'b0);   // saturates to 1.0
        add_value(16'h0000, 1'b1, 1'b1, 0,     1'b0, 1, 1'b0);
        // upper data bits set: only the low three bits select the gate
        add_cfg(fgr_pkg::CFG_GATE_KIND, {13'h1FFF, 3'(fgr_pkg::GK_OR)});
        add_value(16'd100, 1'b0);
        add_value(16'd20000, 1'b1);
        add_cfg(fgr_pkg::CFG_GATE_KIND, 16'(fgr_pkg::GK_NOT));
        add_value(16'd0, 1'b1, 1'b1, 32768, 1'b1, 1, 1'b0);
        add_value(16'd32768, 1'b0);
        add_value(16'd5, 1'b1, 1'b1, 0, 1'b0, 2, 1'b0);
        add_cfg(fgr_pkg::CFG_GATE_KIND, 16'(fgr_pkg::GK_XOR));
        add_value(16'd16384, 1'b0);                                // one high value: mean
        add_value(16'd0, 1'b1, 1'b1, 8192, 1'b0, 2, 1'b0);
        add_value(16'd16384, 1'b0);                                // two high values: zero
        add_value(16'd16384, 1'b1, 1'b1, 0, 1'b0, 2, 1'b0);
        add_cfg(fgr_pkg::CFG_GATE_KIND, 16'(fgr_pkg::GK_IMPLIES));
        add_value(16'd1000, 1'b1, 1'b1, 0, 1'b0, 1, 1'b0);         // single value run
        add_value(16'd32768, 1'b0);
        add_value(16'd7, 1'b1, 1'b1, 7, 1'b0, 2, 1'b0);
        add_cfg(fgr_pkg::CFG_GATE_KIND, 16'(GK_SPARE_LO));
        add_value(16'd32768, 1'b1, 1'b1, 0, 1'b0, 1, 1'b0);
        add_cfg(fgr_pkg::CFG_GATE_KIND, 16'(GK_SPARE_HI));
        add_value(16'd123, 1'b1, 1'b1, 0, 1'b0, 1, 1'b0);
        // threshold above 1.0: nothing ever counts as high
        add_cfg(fgr_pkg::CFG_THRESHOLD, 16'hFFFF);
        add_cfg(fgr_pkg::CFG_GATE_KIND, 16'(fgr_pkg::GK_XOR));
        add_value(16'd32768, 1'b0);
        add_value(16'd32768, 1'b1, 1'b1, 0, 1'b0, 2, 1'b0);
        add_cfg(fgr_pkg::CFG_GATE_KIND, 16'(fgr_pkg::GK_AND));
        add_value(16'd32768, 1'b1, 1'b1, 32768, 1'b0, 1, 1'b0);
        // zero threshold: everything is high
        add_cfg(fgr_pkg::CFG_THRESHOLD, 16'd0);
        add_cfg(fgr_pkg::CFG_GATE_KIND, 16'(fgr_pkg::GK_XOR));
        add_value(16'd0, 1'b1, 1'b1, 0, 1'b1, 1, 1'b0);
        // threshold moved between the values of one run
        add_cfg(fgr_pkg::CFG_THRESHOLD, 16'd16384);
        add_value(16'd20000, 1'b0);
        add_cfg(fgr_pkg::CFG_THRESHOLD, 16'd30000);
        add_value(16'd20000, 1'b1, 1'b1, 20000, 1'b0, 2, 1'b0);
        // writes past the register map must not land anywhere
        add_cfg(CFG_SPARE_A, 16'(fgr_pkg::GK_NOT));
        add_cfg(CFG_SPARE_B, 16'hFFFF);
        add_value(16'd30000, 1'b1, 1'b1, 30000, 1'b1, 1, 1'b0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                cfg_write(plan[i].idx, plan[i].data);
            else
                send_belief(plan[i].data, plan[i].last, plan[i].typed, plan[i].want);
        end

        // Random runs under three idle mixes; each segment rotates the gate kind
        // and draws a new threshold.
        seg = 0;
        for (int mode = 0; mode < 3; mode++) begin
            cfg_write(fgr_pkg::CFG_THRESHOLD, cur_thresh);   // drains before the mix changes
            src_idle   = (mode == 0) ? 28 : (mode == 1) ? 56 : 0;
            snk_idle   = (mode == 0) ? 56 : (mode == 1) ? 28 : 0;
            mode_items = 0;
            while (mode_items < ITEMS_PER_MODE) begin
                cfg_write(fgr_pkg::CFG_GATE_KIND, {13'($urandom), 3'(seg)});
                cfg_write(fgr_pkg::CFG_THRESHOLD, pick_threshold());
                if ($urandom_range(0, 3) == 0)
                    cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                              16'($urandom));
                seg_end = mode_items + $urandom_range(40, 120);
                while (mode_items < seg_end) begin
                    len = pick_run_len();
                    for (int k = 0; k < len; k++)
                        send_belief(pick_belief(), k == len - 1, 1'b0, none);
                    mode_items += len;
                end
                seg++;
            end
        end

        i_in_valid <= 1'b0;
        while (gate_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered: %0d values in %0d runs, %0d register writes, %0d mismatches",
                 n_items, n_results, n_cfg, n_errors);
        $display("All eight gate kinds, thresholds 0 to 0xFFFF, saturation, overlong runs, "
                 , "three idle mixes");
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ fuzzy_gate_reducer.f @@
sv/fgr_pkg.sv
sv/fgr_accum.sv
sv/fgr_div.sv
sv/fuzzy_gate_reducer.sv
tb/sv/tb_fuzzy_gate_reducer.sv
